// ===== rtl/rgbc_pkg.sv =====
// Shared types, constants and helper functions for the RGB 3x3 convolution filter.
// Has no dependencies; every other file in rtl/ imports it.
`timescale 1ns / 1ps
package rgbc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int KERNEL     = 3;
  localparam int TAPS       = KERNEL * KERNEL;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int DIM_W  = 11;
  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int COEF_W = 16;
  localparam int CROW_W = KERNEL * COEF_W;
  localparam int DIV_W  = 15;
  localparam int ACC_W  = 29;
  localparam int MAG_W  = ACC_W - 1;
  localparam int PROD_W = CH_W + 1 + COEF_W;
  localparam int TAP_W  = $clog2(TAPS);
  localparam int DCNT_W = $clog2(MAG_W);
  localparam int QDEPTH = 2;
  localparam int QA_W   = $clog2(QDEPTH);
  localparam int QC_W   = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = CROW_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH   = 3'd0,
    CFG_HEIGHT  = 3'd1,
    CFG_DIVISOR = 3'd2,
    CFG_COEF_T  = 3'd3,
    CFG_COEF_M  = 3'd4,
    CFG_COEF_B  = 3'd5
  } cfg_idx_t;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [TAPS-1:0][PIX_W-1:0] window_t;

  typedef struct packed {
    window_t win;
    logic    frame_end;
  } item_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } front_cfg_t;

  typedef struct packed {
    logic [CROW_W-1:0] coef_top;
    logic [CROW_W-1:0] coef_mid;
    logic [CROW_W-1:0] coef_bot;
    logic [DIV_W-1:0]  divisor;
  } back_cfg_t;

  // Clamp a frame dimension to the range the line stores support.
  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < DIM_W'(KERNEL)) r = DIM_W'(KERNEL);
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

// ===== rtl/rgbc_queue.sv =====
// Two-entry queue carrying 3x3 windows from the front end to the arithmetic back end.
// Depends on rgbc_pkg.
`timescale 1ns / 1ps
module rgbc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rgbc_pkg::item_t push_item,
  output logic          full,
  input  logic          pop,
  output logic          nonempty,
  output rgbc_pkg::item_t pop_item
);
  import rgbc_pkg::*;

  item_t            slots [QDEPTH];
  logic [QA_W-1:0]  wr_ptr;
  logic [QA_W-1:0]  rd_ptr;
  logic [QC_W-1:0]  count;

  assign full     = (count == QC_W'(QDEPTH));
  assign nonempty = (count != '0);
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !nonempty))
    else $error("queue read while empty");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue fill count did not follow a lone write");

endmodule

// ===== rtl/rgbc_front.sv =====
// Front end: takes pixel beats, keeps the two line stores and the 3x3 window,
// decides which pixels are interior and queues their windows. Depends on rgbc_pkg.
`timescale 1ns / 1ps
module rgbc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  rgbc_pkg::front_cfg_t cfg,
  input  logic                 pixel_valid,
  output logic                 pixel_stall,
  input  logic [7:0]           red_in,
  input  logic [7:0]           green_in,
  input  logic [7:0]           blue_in,
  input  logic                 q_full,
  output logic                 push,
  output rgbc_pkg::item_t      push_item
);
  import rgbc_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE   = 2'b01,
    F_UPDATE = 2'b10
  } fstate_t;

  fstate_t           state;
  pixel_t            pix;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  pixel_t            line_upper [MAX_WIDTH];
  pixel_t            line_lower [MAX_WIDTH];
  pixel_t            rd_upper;
  pixel_t            rd_lower;
  window_t           win;
  window_t           win_next;
  logic [DIM_W-1:0]  w_eff;
  logic [DIM_W-1:0]  h_eff;
  logic [DIM_W-1:0]  col_x;
  logic [DIM_W-1:0]  row_x;
  logic              accept;
  logic              interior;

  assign w_eff  = sat_dim(cfg.width, DIM_W'(MAX_WIDTH));
  assign h_eff  = sat_dim(cfg.height, DIM_W'(MAX_HEIGHT));
  assign col_x  = DIM_W'(col);
  assign row_x  = DIM_W'(row);

  assign pixel_stall = !(state == F_IDLE && !q_full);
  assign accept      = pixel_valid && !pixel_stall;

  always_comb begin
    for (int r = 0; r < KERNEL; r++) begin
      for (int k = 0; k < KERNEL - 1; k++) begin
        win_next[r*KERNEL+k] = win[r*KERNEL+k+1];
      end
    end
    win_next[KERNEL-1]        = rd_upper;
    win_next[2*KERNEL-1]      = rd_lower;
    win_next[KERNEL*KERNEL-1] = pix;
  end

  assign interior = (row_x >= DIM_W'(2)) && (col_x >= DIM_W'(2))
                    && (row_x < h_eff) && (col_x < w_eff);
  assign push     = (state == F_UPDATE) && interior;
  assign push_item.win       = win_next;
  assign push_item.frame_end = (row_x == h_eff - 1'b1) && (col_x == w_eff - 1'b1);

  // Line stores: read on acceptance, written back in the update cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_upper <= line_upper[col];
      rd_lower <= line_lower[col];
    end
    if (state == F_UPDATE) begin
      line_upper[col] <= rd_lower;
      line_lower[col] <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) pix <= {red_in, green_in, blue_in};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      col   <= '0;
      row   <= '0;
      win   <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) state <= F_UPDATE;
        end
        F_UPDATE: begin
          state <= F_IDLE;
          win   <= win_next;
          if (col_x + 1'b1 >= w_eff) begin
            col <= '0;
            if (row_x + 1'b1 >= h_eff) row <= '0;
            else row <= row + 1'b1;
          end else begin
            col <= col + 1'b1;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("window queued with no room");
  a_update_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == F_UPDATE))
    else $error("accepted pixel not processed");
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state == F_UPDATE) |-> pixel_stall)
    else $error("pixel taken during update");

endmodule

// ===== rtl/rgbc_back.sv =====
// Back end: multiply-accumulates one queued window per channel over its nine taps,
// divides with a bit-serial restoring divider and clamps. Depends on rgbc_pkg.
`timescale 1ns / 1ps
module rgbc_back (
  input  logic                clk,
  input  logic                rst,
  input  rgbc_pkg::back_cfg_t cfg,
  input  logic                q_nonempty,
  input  rgbc_pkg::item_t     q_item,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [7:0]          red_out,
  output logic [7:0]          green_out,
  output logic [7:0]          blue_out,
  output logic                frame_end
);
  import rgbc_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_MAC  = 4'b0010,
    B_DIV  = 4'b0100,
    B_HOLD = 4'b1000
  } bstate_t;

  bstate_t                  state;
  item_t                    cur;
  logic [TAP_W-1:0]         tap;
  logic [1:0]               krow;
  logic [1:0]               kcol;
  logic signed [ACC_W-1:0]  acc [3];
  logic [MAG_W-1:0]         quo [3];
  logic [DIV_W-1:0]         rem [3];
  logic                     neg [3];
  logic [DCNT_W-1:0]        dcnt;
  logic [CROW_W-1:0]        crow;
  logic signed [COEF_W-1:0] coef;
  pixel_t                   px;
  logic signed [PROD_W-1:0] prod [3];
  logic [DIV_W:0]           dvs;
  logic [DIV_W:0]           trial [3];
  logic                     qbit [3];
  logic [CH_W-1:0]          clamped [3];
  logic                     slot_free;

  assign pop       = (state == B_IDLE) && q_nonempty;
  assign slot_free = !result_valid || !result_stall;
  assign dvs       = (cfg.divisor == '0) ? (DIV_W+1)'(1) : {1'b0, cfg.divisor};

  always_comb begin
    case (krow)
      2'd0:    crow = cfg.coef_top;
      2'd1:    crow = cfg.coef_mid;
      default: crow = cfg.coef_bot;
    endcase
    coef = $signed(crow[kcol*COEF_W +: COEF_W]);
    px   = cur.win[tap];
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch]  = $signed({1'b0, px[(2-ch)*CH_W +: CH_W]}) * coef;
      trial[ch] = {rem[ch], quo[ch][MAG_W-1]};
      qbit[ch]  = (trial[ch] >= dvs);
      if (neg[ch]) clamped[ch] = '0;
      else if (quo[ch] > MAG_W'(255)) clamped[ch] = '1;
      else clamped[ch] = quo[ch][CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= q_item;
    for (int ch = 0; ch < 3; ch++) begin
      if (pop) begin
        acc[ch] <= '0;
      end else if (state == B_MAC) begin
        acc[ch] <= acc[ch] + ACC_W'(prod[ch]);
        if (tap == TAP_W'(TAPS - 1)) begin
          neg[ch] <= (acc[ch] + ACC_W'(prod[ch])) < 0;
          quo[ch] <= MAG_W'(acc[ch] + ACC_W'(prod[ch]));
          rem[ch] <= '0;
        end
      end else if (state == B_DIV) begin
        rem[ch] <= qbit[ch] ? DIV_W'(trial[ch] - dvs) : DIV_W'(trial[ch]);
        quo[ch] <= {quo[ch][MAG_W-2:0], qbit[ch]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_HOLD && slot_free) begin
      red_out   <= clamped[0];
      green_out <= clamped[1];
      blue_out  <= clamped[2];
      frame_end <= cur.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      tap          <= '0;
      krow         <= '0;
      kcol         <= '0;
      dcnt         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (state == B_HOLD && slot_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (pop) begin
            state <= B_MAC;
            tap   <= '0;
            krow  <= '0;
            kcol  <= '0;
          end
        end
        B_MAC: begin
          tap <= tap + 1'b1;
          if (kcol == 2'd2) begin
            kcol <= '0;
            krow <= krow + 1'b1;
          end else begin
            kcol <= kcol + 1'b1;
          end
          if (tap == TAP_W'(TAPS - 1)) begin
            state <= B_DIV;
            dcnt  <= '0;
          end
        end
        B_DIV: begin
          dcnt <= dcnt + 1'b1;
          if (dcnt == DCNT_W'(MAG_W - 1)) state <= B_HOLD;
        end
        B_HOLD: begin
          if (slot_free) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst) pop |=> (state == B_MAC))
    else $error("taken window did not start accumulation");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (state == B_HOLD && slot_free) |=> result_valid)
    else $error("result not presented");
  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    (state == B_MAC) |-> (tap < TAP_W'(TAPS)))
    else $error("tap counter out of range");

endmodule

// ===== rtl/rgb_convolution_3x3.sv =====
// Top level of the RGB 3x3 convolution filter: configuration registers and the
// front end, window queue and arithmetic back end. Depends on rgbc_pkg and submodules.
`timescale 1ns / 1ps
//
//  Channel    Direction  Handshake              Beat
//  pixel      in         pixel_valid/stall      red_in, green_in, blue_in
//  result     out        result_valid/stall     red_out, green_out, blue_out, frame_end
//  cfg        in         cfg_valid/ready        cfg_index, cfg_data
//
// The front end takes a pixel beat only in its idle state and while the queue has
// room: accepting a beat reads the line stores, and the update state then updates
// the window and writes the stores back, so no beat is taken during an update.
// For each interior pixel the back end takes the window from the queue, does the
// multiply-accumulate (one tap per cycle, three channels in parallel), runs the
// bit-serial restoring division, loads the output register once it is free and
// only then takes the next window. The back end therefore sets the sustained rate
// for interior pixels; border pixels pass only through the front end.
// Reset (rst, synchronous) clears counters, window, queue and state; the line
// stores are not cleared and fill as the first two rows pass.
// A stalled result holds in the output register while the queue lets the
// front end keep taking pixels until both queue entries are taken.
module rgb_convolution_3x3 (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pixel_valid,
  output logic                               pixel_stall,
  input  logic [7:0]                         red_in,
  input  logic [7:0]                         green_in,
  input  logic [7:0]                         blue_in,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [7:0]                         red_out,
  output logic [7:0]                         green_out,
  output logic [7:0]                         blue_out,
  output logic                               frame_end,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rgbc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rgbc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rgbc_pkg::*;

  front_cfg_t fcfg;
  back_cfg_t  bcfg;
  logic       q_full;
  logic       q_nonempty;
  logic       push;
  logic       pop;
  item_t      push_item;
  item_t      pop_item;

  // Registers are always writable; writes to unused indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fcfg.width    <= DIM_W'(MAX_WIDTH);
      fcfg.height   <= DIM_W'(MAX_HEIGHT);
      bcfg.divisor  <= DIV_W'(1);
      bcfg.coef_top <= '0;
      bcfg.coef_mid <= CROW_W'(1) << COEF_W;
      bcfg.coef_bot <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WIDTH:   fcfg.width    <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT:  fcfg.height   <= cfg_data[DIM_W-1:0];
        CFG_DIVISOR: bcfg.divisor  <= cfg_data[DIV_W-1:0];
        CFG_COEF_T:  bcfg.coef_top <= cfg_data[CROW_W-1:0];
        CFG_COEF_M:  bcfg.coef_mid <= cfg_data[CROW_W-1:0];
        CFG_COEF_B:  bcfg.coef_bot <= cfg_data[CROW_W-1:0];
        default: ;
      endcase
    end
  end

  rgbc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (fcfg),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .red_in      (red_in),
    .green_in    (green_in),
    .blue_in     (blue_in),
    .q_full      (q_full),
    .push        (push),
    .push_item   (push_item)
  );

  rgbc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .nonempty  (q_nonempty),
    .pop_item  (pop_item)
  );

  rgbc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (bcfg),
    .q_nonempty   (q_nonempty),
    .q_item       (pop_item),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .frame_end    (frame_end)
  );

endmodule

// ===== test/tb_rgb_convolution_3x3.sv =====
// Self-checking testbench for the RGB 3x3 convolution filter: random frames are
// streamed through the block and every filtered pixel is checked against a local
// predictor. Depends on rgbc_pkg and the RTL top level rgb_convolution_3x3.
`timescale 1ns / 1ps
module tb_rgb_convolution_3x3;
  import rgbc_pkg::*;

  // Expected beat on the result channel.
  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       fend;
  } filtered_t;

  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_HOLD  = 400;
  localparam int DRAIN_WAIT = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        pixel_valid = 1'b0;
  logic        pixel_stall;
  logic [7:0]  red_in = '0, green_in = '0, blue_in = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [7:0]  red_out, green_out, blue_out;
  logic        frame_end;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rgb_convolution_3x3 u_top (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .result_valid(result_valid), .result_stall(result_stall),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
    .frame_end(frame_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pixels waiting to be sent, packed red in the top byte, blue in the bottom.
  logic [23:0] pixel_q[$];
  filtered_t   filtered_q[$];

  int errors = 0;
  int pixels_sent = 0;
  int results_seen = 0;
  int frames_sent = 0;
  int phases_run = 0;

  // Shadow copy of the configuration registers, as last written.
  logic [10:0] width_reg = 11'd1024;
  logic [10:0] height_reg = 11'd1024;
  logic [14:0] div_reg = 15'd1;
  logic [47:0] coef_rows[3] = '{48'd0, 48'd65536, 48'd0};

  // Shadow copy of the block's pixel state. The line stores start unknown, but
  // the stimulus never lets an unwritten entry reach a result.
  logic [23:0] upper_line[MAX_WIDTH];
  logic [23:0] lower_line[MAX_WIDTH];
  logic [23:0] win[3][3] = '{default: '0};
  int col_pos = 0;
  int row_pos = 0;

  function automatic int sat_size(input int v, input int hi);
    return (v < 3) ? 3 : (v > hi) ? hi : v;
  endfunction

  // Weighted sum of one channel of the window, divided and clamped to a byte.
  function automatic logic [7:0] filter_channel(input int sh);
    int sum;
    int d;
    sum = 0;
    d = (div_reg == 0) ? 1 : int'(div_reg);
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++)
        sum += int'(win[r][k][sh +: 8]) * int'($signed(coef_rows[r][16*k +: 16]));
    sum = sum / d;
    if (sum < 0) sum = 0;
    else if (sum > 255) sum = 255;
    return 8'(sum);
  endfunction

  // Advances the window by one accepted pixel and queues the filtered pixel
  // when the window is centred on an interior position of the frame.
  function automatic void convolve_pixel(input logic [23:0] px);
    int w;
    int h;
    int c;
    filtered_t f;
    w = sat_size(int'(width_reg), MAX_WIDTH);
    h = sat_size(int'(height_reg), MAX_HEIGHT);
    c = col_pos % MAX_WIDTH;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = upper_line[c];
    win[1][2] = lower_line[c];
    win[2][2] = px;
    upper_line[c] = lower_line[c];
    lower_line[c] = px;
    if (row_pos >= 2 && col_pos >= 2 && row_pos < h && col_pos < w) begin
      f.red   = filter_channel(16);
      f.green = filter_channel(8);
      f.blue  = filter_channel(0);
      f.fend  = (row_pos == h - 1 && col_pos == w - 1);
      filtered_q.push_back(f);
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endfunction

  // Sender: a gap of random length is drawn for every beat, except during
  // back-to-back stretches, which come and go at random.
  int  send_gap = 0;
  bit  send_burst = 1'b0;

  always @(posedge clk) begin
    logic [23:0] nxt;
    bit          load;
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      load = !pixel_valid;
      if (pixel_valid && !pixel_stall) begin
        convolve_pixel({red_in, green_in, blue_in});
        pixels_sent++;
        if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 5);
        load = 1'b1;
      end
      if (load) begin
        if (send_gap > 0) begin
          send_gap--;
          pixel_valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          nxt = pixel_q.pop_front();
          red_in <= nxt[23:16];
          green_in <= nxt[15:8];
          blue_in <= nxt[7:0];
          pixel_valid <= 1'b1;
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result beat against the oldest expectation, then
  // draws its own stall. Once, early in the run, it holds off for a long
  // stretch so that the block backs up and stalls the pixel channel.
  int  stall_wait = 0;
  int  long_hold = 0;
  bit  long_done = 1'b0;
  bit  recv_burst = 1'b0;

  always @(posedge clk) begin
    filtered_t e;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (filtered_q.size() == 0) begin
          errors++;
          $error("result beat with nothing expected: %0d %0d %0d fe=%0b",
                 red_out, green_out, blue_out, frame_end);
        end else begin
          e = filtered_q.pop_front();
          if (red_out !== e.red) begin
            errors++;
            $error("red_out: expected %0d, got %0d", e.red, red_out);
          end
          if (green_out !== e.green) begin
            errors++;
            $error("green_out: expected %0d, got %0d", e.green, green_out);
          end
          if (blue_out !== e.blue) begin
            errors++;
            $error("blue_out: expected %0d, got %0d", e.blue, blue_out);
          end
          if (frame_end !== e.fend) begin
            errors++;
            $error("frame_end: expected %0b, got %0b", e.fend, frame_end);
          end
        end
        if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
        stall_wait = recv_burst ? 0 : $urandom_range(0, 5);
        if (results_seen == 40 && !long_done) begin
          long_hold = LONG_HOLD;
          long_done = 1'b1;
        end
      end
      if (long_hold > 0) begin
        long_hold--;
        result_stall <= 1'b1;
      end else if (stall_wait > 0) begin
        stall_wait--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Watchdog: any stretch without a single beat on any channel is a hang.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready) || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Leaves cfg_valid high; the caller lowers it after the last write so that
  // back-to-back writes never lower and raise it within one step.
  task automatic write_reg(input cfg_idx_t idx, input logic [47:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WIDTH:   width_reg = val[10:0];
      CFG_HEIGHT:  height_reg = val[10:0];
      CFG_DIVISOR: div_reg = val[14:0];
      CFG_COEF_T:  coef_rows[0] = val;
      CFG_COEF_M:  coef_rows[1] = val;
      CFG_COEF_B:  coef_rows[2] = val;
      default: ;
    endcase
  endtask

  // Mostly small signed taps so that sums stay in range; now and then any value.
  function automatic logic [47:0] rand_coef_row();
    logic [47:0] row;
    for (int k = 0; k < 3; k++)
      row[16*k +: 16] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 32) - 16);
    return row;
  endfunction

  // Pattern 0 is random, 1 alternates full and empty pixels, 2 is all full.
  task automatic run_phase(input logic [10:0] w, input logic [10:0] h,
                           input logic [14:0] dv, input logic [47:0] ct,
                           input logic [47:0] cm, input logic [47:0] cb,
                           input int pattern, input int nframes);
    int npix;
    write_reg(CFG_WIDTH, 48'(w));
    write_reg(CFG_HEIGHT, 48'(h));
    write_reg(CFG_DIVISOR, 48'(dv));
    write_reg(CFG_COEF_T, ct);
    write_reg(CFG_COEF_M, cm);
    write_reg(CFG_COEF_B, cb);
    cfg_valid <= 1'b0;
    npix = sat_size(int'(w), MAX_WIDTH) * sat_size(int'(h), MAX_HEIGHT);
    for (int f = 0; f < nframes; f++) begin
      for (int i = 0; i < npix; i++) begin
        case (pattern)
          1:       pixel_q.push_back((i % 2) ? 24'hFFFFFF : 24'h000000);
          2:       pixel_q.push_back(24'hFFFFFF);
          default: pixel_q.push_back(24'($urandom));
        endcase
      end
      frames_sent++;
    end
    // Wait until every pixel is sent and every expected result is seen, then let the block settle.
    while (pixel_q.size() > 0 || pixel_valid || filtered_q.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    phases_run++;
  endtask

  initial begin
    logic [14:0] dv;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: identity filter on a checkerboard, the largest and the
    // most negative taps, out-of-range sizes and a zero divisor.
    run_phase(11'd3, 11'd3, 15'd1, 48'd0, 48'h0000_0001_0000, 48'd0, 1, 1);
    run_phase(11'd3, 11'd3, 15'd32767, {3{16'h7FFF}}, {3{16'h7FFF}},
              {3{16'h7FFF}}, 2, 1);
    run_phase(11'd3, 11'd3, 15'd1, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, 2, 1);
    run_phase(11'd2, 11'd0, 15'd0, rand_coef_row(), rand_coef_row(),
              rand_coef_row(), 0, 1);

    // Random part: small frames with random taps and divisors.
    while (pixels_sent < 1150) begin
      dv = ($urandom_range(0, 4) == 0) ? 15'($urandom_range(1, 32767))
                                       : 15'($urandom_range(1, 64));
      run_phase(11'($urandom_range(3, 12)), 11'($urandom_range(3, 8)), dv,
                rand_coef_row(), rand_coef_row(), rand_coef_row(), 0,
                $urandom_range(1, 2));
    end

    $display("Streamed %0d pixels in %0d frames over %0d register settings.",
             pixels_sent, frames_sent, phases_run);
    $display("Checked %0d filtered pixels, %0d mismatches.", results_seen, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rgbc_pkg.sv
rtl/rgbc_queue.sv
rtl/rgbc_front.sv
rtl/rgbc_back.sv
rtl/rgb_convolution_3x3.sv
test/tb_rgb_convolution_3x3.sv
